// ===== design/wspe_pkg.sv =====
package wspe_pkg;

	localparam logic [1:0] MODE_ADD      = 2'd0;
	localparam logic [1:0] MODE_QUERY    = 2'd1;
	localparam logic [1:0] MODE_CLEAR    = 2'd2;
	localparam logic [1:0] MODE_RESERVED = 2'd3;

	localparam int MAX_RESULTS = 16;
	localparam logic [19:0] COST_SAT = 20'hFFFFF;

	typedef struct packed {
		logic [1:0]  mode;
		logic [3:0]  src_vertex;
		logic [3:0]  dst_vertex;
		logic [15:0] edge_weight;
		logic        both_ways;
	} in_item_t;

	typedef struct packed {
		logic [3:0]  path_vertex;
		logic [19:0] total_cost;
		logic [4:0]  path_length;
		logic        unreachable;
		logic        last_of_path;
	} out_item_t;

	typedef enum logic [1:0] {
		CMD_EDGE  = 2'd0,
		CMD_QUERY = 2'd1,
		CMD_CLEAR = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic        bad;
		logic [3:0]  src;
		logic [3:0]  dst;
		logic [15:0] weight;
		logic        both;
	} cmd_t;

endpackage

// ===== design/wspe_ram.sv =====
module wspe_ram import wspe_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== design/wspe_front.sv =====
module wspe_front import wspe_pkg::*; #(
	parameter int NUM_VERTICES = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  in_item_t item,
	output logic     q_valid,
	output cmd_t     q_cmd,
	input  logic     q_pop
);

	localparam logic [6:0] NV7 = 7'(NUM_VERTICES);

	cmd_t       ent_q [2];
	logic [1:0] cnt_q;
	logic       rd_q;
	logic       src_ok, dst_ok, keep, push;
	cmd_t       cmd;

	assign src_ok = ({3'b000, item.src_vertex} < NV7);
	assign dst_ok = ({3'b000, item.dst_vertex} < NV7);

	// classify: out-of-range edges and the unused mode are dropped here
	always_comb begin
		cmd.src    = item.src_vertex;
		cmd.dst    = item.dst_vertex;
		cmd.weight = item.edge_weight;
		cmd.both   = item.both_ways;
		cmd.bad    = !(src_ok && dst_ok);
		cmd.kind   = CMD_EDGE;
		keep       = 1'b0;
		unique case (item.mode)
			MODE_ADD: begin
				cmd.kind = CMD_EDGE;
				keep     = src_ok && dst_ok;
			end
			MODE_QUERY: begin
				cmd.kind = CMD_QUERY;
				keep     = 1'b1;
			end
			MODE_CLEAR: begin
				cmd.kind = CMD_CLEAR;
				keep     = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign busy    = (cnt_q == 2'd2);
	assign push    = start && !busy && keep;
	assign q_valid = (cnt_q != 2'd0);
	assign q_cmd   = ent_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			rd_q  <= 1'b0;
		end else begin
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
			if (q_pop) begin
				rd_q <= !rd_q;
			end
		end
	end

	// write slot is the read pointer plus the fill count
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[rd_q ^ cnt_q[0]] <= cmd;
		end
	end

endmodule

// ===== design/wspe_back.sv =====
module wspe_back import wspe_pkg::*; #(
	parameter int NUM_VERTICES = 16,
	parameter int WEIGHT_BITS  = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_valid,
	input  cmd_t      q_cmd,
	output logic      q_pop,
	output logic      valid,
	output out_item_t result
);

	localparam int NV  = NUM_VERTICES;
	localparam int WB  = WEIGHT_BITS;
	localparam int VW  = $clog2(NV);
	localparam int AW  = $clog2(NV * NV);
	localparam int CW  = WB + VW;
	localparam int SW  = $clog2(NV * NV + 2);
	localparam int LW  = $clog2(NV + 1);
	localparam int LX  = (LW > 5) ? LW : 5;
	localparam int CXW = (CW > 20) ? CW : 20;
	localparam int VSW = CW + VW + SW;
	localparam logic [VW-1:0] LAST_V = VW'(NV - 1);
	localparam logic [AW-1:0] LAST_A = AW'(NV * NV - 1);

	typedef enum logic [12:0] {
		S_SWEEP  = 13'b0000000000001,
		S_IDLE   = 13'b0000000000010,
		S_ERD    = 13'b0000000000100,
		S_EWR    = 13'b0000000001000,
		S_QINIT  = 13'b0000000010000,
		S_SEL    = 13'b0000000100000,
		S_SETTLE = 13'b0000001000000,
		S_REL    = 13'b0000010000000,
		S_BT     = 13'b0000100000000,
		S_BTW    = 13'b0001000000000,
		S_ORD    = 13'b0010000000000,
		S_OWR    = 13'b0100000000000,
		S_UNR    = 13'b1000000000000
	} state_t;

	state_t          state_q;
	logic [AW-1:0]   sweep_q;
	logic [VW-1:0]   ca_q, cb_q, start_q, stop_q, bu_q, v_q, i_q, idx_s1;
	logic [WB-1:0]   w_q;
	logic            both_q, second_q, scan_q, rv_s1, found_q;
	logic [NV-1:0]   reached_q, settled_q;
	logic [CW-1:0]   bcost_q;
	logic [SW-1:0]   bstamp_q, clock_q;
	logic [LW-1:0]   len_q;
	logic [4:0]      k_q;
	logic            valid_q;
	out_item_t       result_q;

	logic            adj_we, adj_re;
	logic [AW-1:0]   adj_waddr, adj_raddr;
	logic [WB:0]     adj_wdata, adj_rdata;
	logic            vs_we, vs_re;
	logic [VW-1:0]   vs_waddr, vs_raddr;
	logic [VSW-1:0]  vs_wdata, vs_rdata;
	logic            ch_we, ch_re;
	logic [VW-1:0]   ch_waddr, ch_raddr, ch_rdata;

	logic [CW-1:0]   rd_cost, relax_c;
	logic [VW-1:0]   rd_pred;
	logic [SW-1:0]   rd_stamp;
	logic            better, relax, cand;
	logic [AW-1:0]   edge_idx, rel_idx;
	logic [LX-1:0]   nres, chain_pos;
	logic [CXW-1:0]  cost_x;
	logic [19:0]     cost_out;

	assign rd_cost  = vs_rdata[VSW-1 -: CW];
	assign rd_pred  = vs_rdata[SW +: VW];
	assign rd_stamp = vs_rdata[SW-1:0];

	assign edge_idx = AW'(AW'(ca_q) * AW'(NV) + AW'(cb_q));
	assign rel_idx  = AW'(AW'(bu_q) * AW'(NV) + AW'(i_q));

	assign cand   = reached_q[idx_s1] && !settled_q[idx_s1];
	assign better = !found_q || (rd_cost < bcost_q) ||
		((rd_cost == bcost_q) && (rd_stamp > bstamp_q));
	assign relax_c = bcost_q + CW'(adj_rdata[WB-1:0]);
	assign relax   = adj_rdata[WB] && (!reached_q[idx_s1] || (relax_c < rd_cost));

	assign nres      = (LX'(len_q) > LX'(MAX_RESULTS)) ? LX'(MAX_RESULTS) : LX'(len_q);
	assign chain_pos = LX'(len_q) - LX'(1) - LX'(k_q);
	assign cost_x    = CXW'(bcost_q);
	assign cost_out  = (cost_x > CXW'(COST_SAT)) ? COST_SAT : cost_x[19:0];

	always_comb begin
		adj_we    = 1'b0;
		adj_waddr = sweep_q;
		adj_wdata = '0;
		adj_re    = 1'b0;
		adj_raddr = edge_idx;
		vs_we     = 1'b0;
		vs_waddr  = idx_s1;
		vs_wdata  = {relax_c, bu_q, clock_q};
		vs_re     = 1'b0;
		vs_raddr  = i_q;
		ch_we     = 1'b0;
		ch_waddr  = len_q[VW-1:0];
		ch_re     = 1'b0;
		ch_raddr  = chain_pos[VW-1:0];
		q_pop     = 1'b0;
		unique case (state_q)
			S_SWEEP: begin
				adj_we = 1'b1;
			end
			S_IDLE: begin
				q_pop = q_valid;
			end
			S_ERD: begin
				adj_re = 1'b1;
			end
			S_EWR: begin
				adj_we    = 1'b1;
				adj_waddr = edge_idx;
				// keep the old weight unless the new one is strictly smaller
				adj_wdata = {1'b1, (adj_rdata[WB] && !(w_q < adj_rdata[WB-1:0])) ?
					adj_rdata[WB-1:0] : w_q};
			end
			S_QINIT: begin
				vs_we    = 1'b1;
				vs_waddr = start_q;
				vs_wdata = {{CW{1'b0}}, start_q, {SW{1'b0}}};
			end
			S_SEL: begin
				vs_re = scan_q;
			end
			S_REL: begin
				vs_re     = scan_q;
				adj_re    = scan_q;
				adj_raddr = rel_idx;
				vs_we     = rv_s1 && relax;
			end
			S_BT: begin
				ch_we    = 1'b1;
				vs_re    = 1'b1;
				vs_raddr = v_q;
			end
			S_ORD: begin
				ch_re = 1'b1;
			end
			S_SETTLE, S_BTW, S_OWR, S_UNR: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_SWEEP;
			sweep_q   <= '0;
			scan_q    <= 1'b0;
			rv_s1     <= 1'b0;
			valid_q   <= 1'b0;
			reached_q <= '0;
			settled_q <= '0;
			found_q   <= 1'b0;
			second_q  <= 1'b0;
			clock_q   <= '0;
			len_q     <= '0;
			k_q       <= '0;
		end else begin
			valid_q <= 1'b0;
			unique case (state_q)
				S_SWEEP: begin
					sweep_q <= sweep_q + AW'(1);
					if (sweep_q == LAST_A) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (q_valid) begin
						second_q <= 1'b0;
						unique case (q_cmd.kind)
							CMD_EDGE: state_q <= S_ERD;
							CMD_QUERY: state_q <= q_cmd.bad ? S_UNR : S_QINIT;
							CMD_CLEAR: begin
								sweep_q <= '0;
								state_q <= S_SWEEP;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_ERD: begin
					state_q <= S_EWR;
				end
				S_EWR: begin
					if (both_q && !second_q) begin
						second_q <= 1'b1;
						state_q  <= S_ERD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_QINIT: begin
					reached_q          <= '0;
					reached_q[start_q] <= 1'b1;
					settled_q          <= '0;
					clock_q            <= SW'(1);
					found_q            <= 1'b0;
					scan_q             <= 1'b1;
					state_q            <= S_SEL;
				end
				S_SEL: begin
					rv_s1 <= scan_q;
					if (scan_q && i_q == LAST_V) begin
						scan_q <= 1'b0;
					end
					if (rv_s1) begin
						if (cand && better) begin
							found_q <= 1'b1;
						end
						if (idx_s1 == LAST_V) begin
							state_q <= S_SETTLE;
						end
					end
				end
				S_SETTLE: begin
					if (!found_q) begin
						state_q <= S_UNR;
					end else begin
						settled_q[bu_q] <= 1'b1;
						if (bu_q == stop_q) begin
							len_q   <= '0;
							state_q <= S_BT;
						end else begin
							scan_q  <= 1'b1;
							state_q <= S_REL;
						end
					end
				end
				S_REL: begin
					rv_s1 <= scan_q;
					if (scan_q && i_q == LAST_V) begin
						scan_q <= 1'b0;
					end
					if (rv_s1) begin
						if (relax) begin
							reached_q[idx_s1] <= 1'b1;
							clock_q           <= clock_q + SW'(1);
						end
						if (idx_s1 == LAST_V) begin
							found_q <= 1'b0;
							scan_q  <= 1'b1;
							state_q <= S_SEL;
						end
					end
				end
				S_BT: begin
					len_q <= len_q + LW'(1);
					if (v_q == start_q || (len_q + LW'(1)) == LW'(NV)) begin
						k_q     <= '0;
						state_q <= S_ORD;
					end else begin
						state_q <= S_BTW;
					end
				end
				S_BTW: begin
					state_q <= S_BT;
				end
				S_ORD: begin
					state_q <= S_OWR;
				end
				S_OWR: begin
					valid_q <= 1'b1;
					if (LX'(k_q) + LX'(1) == nres) begin
						state_q <= S_IDLE;
					end else begin
						k_q     <= k_q + 5'd1;
						state_q <= S_ORD;
					end
				end
				S_UNR: begin
					valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload and datapath registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && q_valid) begin
			ca_q    <= VW'(q_cmd.src);
			cb_q    <= VW'(q_cmd.dst);
			start_q <= VW'(q_cmd.src);
			stop_q  <= VW'(q_cmd.dst);
			v_q     <= VW'(q_cmd.dst);
			w_q     <= WB'(q_cmd.weight);
			both_q  <= q_cmd.both;
		end
		if (state_q == S_EWR) begin
			ca_q <= cb_q;
			cb_q <= ca_q;
		end
		if (state_q == S_QINIT || state_q == S_SETTLE ||
			(state_q == S_REL && rv_s1 && idx_s1 == LAST_V)) begin
			i_q <= '0;
		end else if (scan_q && (state_q == S_SEL || state_q == S_REL)) begin
			i_q <= i_q + VW'(1);
		end
		idx_s1 <= i_q;
		if (state_q == S_SEL && rv_s1 && cand && better) begin
			bu_q     <= idx_s1;
			bcost_q  <= rd_cost;
			bstamp_q <= rd_stamp;
		end
		if (state_q == S_BTW) begin
			v_q <= rd_pred;
		end
		if (state_q == S_OWR) begin
			result_q.path_vertex  <= 4'(ch_rdata);
			result_q.total_cost   <= cost_out;
			result_q.path_length  <= 5'(len_q);
			result_q.unreachable  <= 1'b0;
			result_q.last_of_path <= (LX'(k_q) + LX'(1) == nres);
		end
		if (state_q == S_UNR) begin
			result_q <= '{path_vertex: 4'd0, total_cost: 20'd0, path_length: 5'd0,
				unreachable: 1'b1, last_of_path: 1'b1};
		end
	end

	assign valid  = valid_q;
	assign result = result_q;

	wspe_ram #(.WIDTH(WB + 1), .DEPTH(NV * NV)) u_adj (
		.clk   (clk),
		.we    (adj_we),
		.waddr (adj_waddr),
		.wdata (adj_wdata),
		.re    (adj_re),
		.raddr (adj_raddr),
		.rdata (adj_rdata)
	);

	wspe_ram #(.WIDTH(VSW), .DEPTH(NV)) u_vstate (
		.clk   (clk),
		.we    (vs_we),
		.waddr (vs_waddr),
		.wdata (vs_wdata),
		.re    (vs_re),
		.raddr (vs_raddr),
		.rdata (vs_rdata)
	);

	wspe_ram #(.WIDTH(VW), .DEPTH(NV)) u_chain (
		.clk   (clk),
		.we    (ch_we),
		.waddr (ch_waddr),
		.wdata (v_q),
		.re    (ch_re),
		.raddr (ch_raddr),
		.rdata (ch_rdata)
	);

	a_unr_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid && result.unreachable |-> result.last_of_path)
		else $error("unreachable result not marked last");

	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> state_q == S_IDLE)
		else $error("command taken while engine busy");

	a_vs_write: assert property (@(posedge clk) disable iff (!arst_n)
		vs_we |-> state_q == S_QINIT || state_q == S_REL)
		else $error("vertex state written outside init or relax");

	a_settle_once: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SETTLE && found_q |-> !settled_q[bu_q])
		else $error("vertex settled twice");

endmodule

// ===== design/weighted_shortest_path_engine.sv =====
// Shortest-path engine over a stored weighted graph. Items are taken while busy is low; the
// front queues up to two commands so the engine can keep working, and busy rises once two are
// waiting. An edge add is a read-modify-write on the adjacency memory, repeated for the
// reverse copy when both ways is set. A clear and the state just after reset sweep the
// adjacency memory one entry per cycle, during which commands only queue. A query runs
// one-entry-per-cycle scans of the vertex state and adjacency memories for each vertex it
// settles before reaching the stop, then traces the path back and emits the results.
// Results appear on result for one cycle with valid high; the receiver cannot stall them.
module weighted_shortest_path_engine import wspe_pkg::*; #(
	parameter int NUM_VERTICES = 16,
	parameter int WEIGHT_BITS  = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  in_item_t  item,
	output logic      valid,
	output out_item_t result
);

	logic q_valid, q_pop;
	cmd_t q_cmd;

	wspe_front #(.NUM_VERTICES(NUM_VERTICES)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.item    (item),
		.q_valid (q_valid),
		.q_cmd   (q_cmd),
		.q_pop   (q_pop)
	);

	wspe_back #(.NUM_VERTICES(NUM_VERTICES), .WEIGHT_BITS(WEIGHT_BITS)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_cmd   (q_cmd),
		.q_pop   (q_pop),
		.valid   (valid),
		.result  (result)
	);

endmodule

// ===== sim/testbench.sv =====
module testbench;
	import wspe_pkg::*;

	localparam int NV = 16;
	localparam int SWEEP = NV * NV;
	localparam int TAIL = 2 * SWEEP + 200;
	localparam longint LIMIT = 4000000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	in_item_t item;
	logic valid;
	out_item_t result;

	weighted_shortest_path_engine u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.valid(valid),
		.result(result)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// predictor state: the stored graph
	logic        adj_present [NV*NV];
	logic [15:0] adj_weight [NV*NV];
	out_item_t   path_q [$];

	int  errors;
	int  n_items;
	int  n_results;
	int  n_queries;
	int  n_unreach;
	longint cycles;

	function automatic void store_edge(int a, int b, logic [15:0] w);
		int idx;
		idx = a * NV + b;
		if (!adj_present[idx] || w < adj_weight[idx])
			adj_weight[idx] = w;
		adj_present[idx] = 1'b1;
	endfunction

	function automatic void push_unreachable();
		out_item_t r;
		r = '0;
		r.unreachable = 1'b1;
		r.last_of_path = 1'b1;
		path_q.push_back(r);
	endfunction

	// shortest path search, ties go to the most recently improved vertex
	function automatic void predict_path(int s, int t);
		logic [63:0] cost [NV];
		logic        seen [NV];
		logic        done [NV];
		int          prev [NV];
		int          stamp [NV];
		int          chain [NV];
		int          tick, u, len, v, n;
		logic        found;
		logic [63:0] c;
		logic [19:0] total;
		out_item_t   r;
		tick = 0;
		for (int i = 0; i < NV; i++) begin
			cost[i] = 0;
			seen[i] = 0;
			done[i] = 0;
			prev[i] = 0;
			stamp[i] = 0;
		end
		seen[s] = 1;
		prev[s] = s;
		stamp[s] = tick++;
		forever begin
			found = 0;
			u = 0;
			for (int i = 0; i < NV; i++) begin
				if (seen[i] && !done[i]) begin
					if (!found || cost[i] < cost[u] ||
					    (cost[i] == cost[u] && stamp[i] > stamp[u])) begin
						u = i;
						found = 1;
					end
				end
			end
			if (!found) begin
				push_unreachable();
				n_unreach++;
				return;
			end
			done[u] = 1;
			if (u == t)
				break;
			for (int i = 0; i < NV; i++) begin
				if (adj_present[u*NV+i]) begin
					c = cost[u] + 64'(adj_weight[u*NV+i]);
					if (!seen[i] || c < cost[i]) begin
						cost[i] = c;
						seen[i] = 1;
						prev[i] = u;
						stamp[i] = tick++;
					end
				end
			end
		end
		total = (cost[t] > 64'hFFFFF) ? COST_SAT : cost[t][19:0];
		len = 0;
		v = t;
		while (len < NV) begin
			chain[len++] = v;
			if (v == s)
				break;
			v = prev[v];
		end
		n = (len > MAX_RESULTS) ? MAX_RESULTS : len;
		for (int k = 0; k < n; k++) begin
			r.path_vertex = 4'(chain[len-1-k]);
			r.total_cost = total;
			r.path_length = 5'(len);
			r.unreachable = 1'b0;
			r.last_of_path = (k == n - 1);
			path_q.push_back(r);
		end
	endfunction

	function automatic void predict(in_item_t it);
		case (it.mode)
			MODE_ADD: begin
				store_edge(int'(it.src_vertex), int'(it.dst_vertex), it.edge_weight);
				if (it.both_ways)
					store_edge(int'(it.dst_vertex), int'(it.src_vertex), it.edge_weight);
			end
			MODE_QUERY: begin
				n_queries++;
				predict_path(int'(it.src_vertex), int'(it.dst_vertex));
			end
			MODE_CLEAR: begin
				for (int i = 0; i < NV*NV; i++)
					adj_present[i] = 1'b0;
			end
			default: ;
		endcase
	endfunction

	// result checker
	always @(posedge clk) begin
		out_item_t exp_r;
		if (arst_n && valid) begin
			n_results++;
			if (path_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result %p", $time, result);
			end else begin
				exp_r = path_q.pop_front();
				if (result.path_vertex !== exp_r.path_vertex ||
				    result.total_cost !== exp_r.total_cost ||
				    result.path_length !== exp_r.path_length ||
				    result.unreachable !== exp_r.unreachable ||
				    result.last_of_path !== exp_r.last_of_path) begin
					errors++;
					$display("%0t: mismatch expected %p actual %p", $time, exp_r, result);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("testbench: errors");
			$finish;
		end
	end

	function automatic in_item_t mk(logic [1:0] m, int a, int b, int w, bit bw);
		in_item_t it;
		it.mode = m;
		it.src_vertex = 4'(a);
		it.dst_vertex = 4'(b);
		it.edge_weight = 16'(w);
		it.both_ways = bw;
		return it;
	endfunction

	task automatic send(in_item_t it, bit allow_gap);
		if (allow_gap && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start <= 1'b1;
		item <= it;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predict(it);
		n_items++;
	endtask

	function automatic in_item_t random_item();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 60)
			return mk(MODE_ADD, $urandom_range(0, 7), $urandom_range(0, 7),
				($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 40),
				$urandom_range(0, 1));
		else if (sel < 92)
			return mk(MODE_QUERY, $urandom_range(0, 7), $urandom_range(0, 7),
				$urandom, $urandom_range(0, 1));
		else if (sel < 96)
			return mk(MODE_CLEAR, $urandom, $urandom, $urandom, $urandom_range(0, 1));
		else
			return mk(MODE_RESERVED, $urandom, $urandom, $urandom, $urandom_range(0, 1));
	endfunction

	typedef struct {
		in_item_t  it;
		bit        has_exp;
		out_item_t exp_r;
	} row_t;

	row_t rows [$];

	initial begin
		out_item_t unr;
		row_t r;
		int wait_cnt;
		unr = '0;
		unr.unreachable = 1'b1;
		unr.last_of_path = 1'b1;
		errors = 0;
		n_items = 0;
		n_results = 0;
		n_queries = 0;
		n_unreach = 0;
		cycles = 0;
		for (int i = 0; i < NV*NV; i++) begin
			adj_present[i] = 1'b0;
			adj_weight[i] = '0;
		end
		start = 1'b0;
		item = '0;
		arst_n = 1'b0;

		// directed table
		rows.push_back('{mk(MODE_QUERY, 0, 1, 0, 0), 1, unr});
		rows.push_back('{mk(MODE_QUERY, 15, 15, 16'hFFFF, 1), 1,
			out_item_t'{4'd15, 20'd0, 5'd1, 1'b0, 1'b1}});
		rows.push_back('{mk(MODE_ADD, 0, 1, 16'hFFFF, 1), 0, unr});
		rows.push_back('{mk(MODE_ADD, 0, 1, 16'hFFFF, 0), 0, unr});
		rows.push_back('{mk(MODE_ADD, 0, 1, 30, 0), 0, unr});
		rows.push_back('{mk(MODE_QUERY, 0, 1, 0, 0), 0, unr});
		rows.push_back('{mk(MODE_QUERY, 1, 0, 0, 0), 0, unr});
		rows.push_back('{mk(MODE_ADD, 5, 5, 7, 1), 0, unr});
		rows.push_back('{mk(MODE_QUERY, 5, 5, 0, 0), 0, unr});
		rows.push_back('{mk(MODE_ADD, 1, 2, 10, 0), 0, unr});
		rows.push_back('{mk(MODE_ADD, 0, 2, 40, 0), 0, unr});
		rows.push_back('{mk(MODE_QUERY, 0, 2, 0, 0), 0, unr});
		rows.push_back('{mk(MODE_RESERVED, 15, 15, 16'hFFFF, 1), 0, unr});
		rows.push_back('{mk(MODE_CLEAR, 0, 0, 0, 0), 0, unr});
		rows.push_back('{mk(MODE_QUERY, 0, 1, 0, 0), 1, unr});
		// chain over all vertices: longest path with the heaviest weights
		for (int i = 0; i < NV - 1; i++)
			rows.push_back('{mk(MODE_ADD, i, i + 1, 16'hFFFF, i[0]), 0, unr});
		rows.push_back('{mk(MODE_QUERY, 0, 15, 0, 0), 0, unr});
		rows.push_back('{mk(MODE_CLEAR, 15, 15, 16'hFFFF, 1), 0, unr});

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[k]) begin
			r = rows[k];
			if (r.has_exp && path_q.size() == 0) begin
				send(r.it, 0);
				start <= 1'b0;
				if (path_q.size() != 1 || path_q[0] !== r.exp_r) begin
					errors++;
					$display("%0t: row %0d expected %p predicted %p", $time, k, r.exp_r,
						(path_q.size() > 0) ? path_q[0] : unr);
				end
			end else
				send(r.it, 1);
		end

		// random part: mostly edges and queries on a small vertex range
		for (int k = 0; k < 266; k++)
			send(random_item(), k < 220);
		// occasional edges and queries touching the top vertices
		for (int k = 0; k < 12; k++)
			send(mk(($urandom_range(0, 1) != 0) ? MODE_QUERY : MODE_ADD,
				$urandom_range(8, 15), $urandom_range(0, 15),
				$urandom, $urandom_range(0, 1)), 0);
		start <= 1'b0;

		wait_cnt = 0;
		while (path_q.size() != 0 && wait_cnt < 200000) begin
			@(posedge clk);
			wait_cnt++;
		end
		repeat (TAIL) @(posedge clk);

		$display("%0d items sent, %0d queries (%0d unreachable), %0d path results checked",
			n_items, n_queries, n_unreach, n_results);
		if (errors == 0 && path_q.size() == 0)
			$display("testbench: clean");
		else begin
			$display("%0d errors, %0d results never arrived", errors, path_q.size());
			$display("testbench: errors");
		end
		$finish;
	end

endmodule
